FILE: hw/rtl/bcpa_pkg.sv
// Shared types and codes for the bitmap contiguous page allocator.
// Used by bcpa_ctrl and the core top level; depends on nothing.
package bcpa_pkg;

	// Fixed field widths
	localparam int ADDR_W = 32;
	localparam int CNT_W  = 11;
	localparam int ACC_W  = ADDR_W + 1;
	localparam int CIDX_W = 2;

	// Request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_BASE_ADDR     = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_MANAGED_PAGES = 2'd1;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_SPACE  = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_NOT_ALLOC = 2'd3
	} status_t;

	// Configuration as seen by the sequencer
	typedef struct packed {
		logic [ADDR_W-1:0] base_addr;
		logic [CNT_W-1:0]  managed;
		logic              set_managed;
		logic [CNT_W-1:0]  new_managed;
	} cfg_t;

	// One result
	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] run_addr;
		logic [CNT_W-1:0]  run_pages;
		logic [CNT_W-1:0]  free_left;
	} res_t;

endpackage

FILE: hw/rtl/bitmap_contiguous_page_allocator_core.sv
// Top level of the bitmap first-fit page allocator: config registers, result register.
// Depends on bcpa_pkg, bcpa_map_ram and bcpa_ctrl.
//
// channel  dir   handshake              payload
// s_*      in    s_tvalid / s_tready    tuser: opcode; tdata: page_request, free_addr
// m_*      out   m_tvalid / m_tready    tuser: status; tdata: run_addr, run_pages, free_left
// cfg_*    in    cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Allocate: a map scan (one page a cycle through the map read port), then marking of
// the run and an address step. Free: an offset search, a check that the run is in use,
// then its release. Writing managed_pages starts a clearing sweep during which no
// request is taken. After reset no page is managed. One request is in work at a time;
// a finished result waits in the output register while m_tready is low.
module bitmap_contiguous_page_allocator_core #(
	parameter int MAX_PAGES  = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [10:0] page_request, [42:11] free_addr, rest zero
	input  logic [0:0]  s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [31:0] run_addr, [42:32] run_pages, [53:43] free_left
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_PAGES);
	localparam int CW    = bcpa_pkg::CNT_W;
	localparam int AW    = bcpa_pkg::ADDR_W;

	logic [AW-1:0]  base_addr_q;
	logic [CW-1:0]  managed_q;
	logic [CW-1:0]  new_managed;
	logic           cfg_wr;
	bcpa_pkg::cfg_t cfg;

	logic           res_valid;
	logic           res_ready;
	bcpa_pkg::res_t res;
	logic           m_valid_q;
	bcpa_pkg::res_t m_res_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic             ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic             ram_rdata;

	// Config writes; page count saturates at the map depth
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign new_managed = (32'(cfg_data[CW-1:0]) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES)
		: cfg_data[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr_q <= '0;
			managed_q   <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == bcpa_pkg::CFG_BASE_ADDR) begin
				base_addr_q <= cfg_data;
			end else if (cfg_index == bcpa_pkg::CFG_MANAGED_PAGES) begin
				managed_q <= new_managed;
			end
		end
	end

	assign cfg.base_addr   = base_addr_q;
	assign cfg.managed     = managed_q;
	assign cfg.set_managed = cfg_wr && (cfg_index == bcpa_pkg::CFG_MANAGED_PAGES);
	assign cfg.new_managed = new_managed;

	// Output register
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_res_q   <= '0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
			m_res_q   <= res;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_res_q.status;
	assign m_tdata  = {2'b00, m_res_q.free_left, m_res_q.run_pages, m_res_q.run_addr};

	bcpa_ctrl #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (s_tuser[0]),
		.in_pages  (s_tdata[10:0]),
		.in_addr   (s_tdata[42:11]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bcpa_map_ram #(
		.DEPTH (MAX_PAGES)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

FILE: hw/rtl/bcpa_map_ram.sv
// One-bit-per-page used map: single write port, single registered read port.
// Standalone; no package dependency.
module bcpa_map_ram #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];
	logic rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/bcpa_ctrl.sv
// Sequencer of the page allocator: map scans, marking, address search, clearing.
// Depends on bcpa_pkg; drives the map RAM (bcpa_map_ram) through its ports.
module bcpa_ctrl #(
	parameter int MAX_PAGES  = 1024,
	parameter int PAGE_BYTES = 4096,
	localparam int IDX_W = $clog2(MAX_PAGES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bcpa_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_opcode,
	input  logic [bcpa_pkg::CNT_W-1:0]   in_pages,
	input  logic [bcpa_pkg::ADDR_W-1:0]  in_addr,
	output logic                         res_valid,
	input  logic                         res_ready,
	output bcpa_pkg::res_t               res,
	output logic                         ram_we,
	output logic [IDX_W-1:0]             ram_waddr,
	output logic                         ram_wdata,
	output logic                         ram_re,
	output logic [IDX_W-1:0]             ram_raddr,
	input  logic                         ram_rdata
);

	localparam int CW = bcpa_pkg::CNT_W;
	localparam int AW = bcpa_pkg::ADDR_W;
	localparam int XW = bcpa_pkg::ACC_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_A_SCAN,
		S_A_MARK,
		S_A_ADDR,
		S_F_FIND,
		S_F_CHECK,
		S_F_REL,
		S_RESP
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  ptr_q;
	logic [CW-1:0]  left_q;
	logic [CW-1:0]  run_q;
	logic [CW-1:0]  req_q;
	logic [CW-1:0]  start_q;
	logic [CW-1:0]  free_q;
	logic [AW-1:0]  off_q;
	logic [AW-1:0]  addr_q;
	logic [AW-1:0]  prod_q;
	logic [XW-1:0]  acc_q;
	logic           rd_v_s1;
	bcpa_pkg::res_t res_q;

	logic issue;
	logic hit;
	logic in_range;

	// Map read issue: allocate scan walks the map, free check walks the run
	always_comb begin
		in_range = ptr_q < cfg.managed;
		unique case (state_q)
			S_A_SCAN:  issue = in_range;
			S_F_CHECK: issue = left_q != '0;
			default:   issue = 1'b0;
		endcase
	end

	// A free page that completes the run
	assign hit = rd_v_s1 && !ram_rdata && ((run_q + 1'b1) == req_q);

	assign ram_re    = issue;
	assign ram_raddr = IDX_W'(ptr_q);
	assign ram_waddr = IDX_W'(ptr_q);
	assign ram_we    = ((state_q == S_CLEAR) && in_range) || (state_q == S_A_MARK)
		|| (state_q == S_F_REL);
	assign ram_wdata = state_q == S_A_MARK;

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = state_q == S_RESP;
	assign res       = res_q;

	// Sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
			left_q  <= '0;
			run_q   <= '0;
			req_q   <= '0;
			start_q <= '0;
			free_q  <= '0;
			off_q   <= '0;
			addr_q  <= '0;
			prod_q  <= '0;
			acc_q   <= '0;
			rd_v_s1 <= 1'b0;
			res_q   <= '0;
		end else begin
			if (cfg.set_managed) begin
				// new page count: restart the clearing sweep
				state_q <= S_CLEAR;
				ptr_q   <= '0;
				free_q  <= cfg.new_managed;
				rd_v_s1 <= 1'b0;
			end else begin
				rd_v_s1 <= issue;
				unique case (state_q)
					S_IDLE: begin
						if (in_valid) begin
							req_q  <= in_pages;
							ptr_q  <= '0;
							run_q  <= '0;
							acc_q  <= '0;
							addr_q <= in_addr;
							off_q  <= in_addr - cfg.base_addr;
							if (in_opcode == bcpa_pkg::OP_FREE) begin
								state_q <= S_F_FIND;
							end else if (in_pages == '0 || in_pages > free_q) begin
								res_q   <= '{bcpa_pkg::STAT_NO_SPACE, '0, '0, free_q};
								state_q <= S_RESP;
							end else begin
								state_q <= S_A_SCAN;
							end
						end
					end
					S_CLEAR: begin
						if (in_range) begin
							ptr_q <= ptr_q + 1'b1;
						end else begin
							state_q <= S_IDLE;
						end
					end
					S_A_SCAN: begin
						if (rd_v_s1) begin
							run_q <= ram_rdata ? '0 : run_q + 1'b1;
						end
						if (hit) begin
							// run ends at ptr_q - 1
							ptr_q   <= ptr_q - req_q;
							start_q <= ptr_q - req_q;
							left_q  <= req_q;
							state_q <= S_A_MARK;
						end else if (issue) begin
							ptr_q <= ptr_q + 1'b1;
						end else if (!rd_v_s1) begin
							res_q   <= '{bcpa_pkg::STAT_NO_SPACE, '0, '0, free_q};
							state_q <= S_RESP;
						end
					end
					S_A_MARK: begin
						ptr_q  <= ptr_q + 1'b1;
						left_q <= left_q - 1'b1;
						prod_q <= AW'(start_q) * AW'(PAGE_BYTES);
						if (left_q == CW'(1)) begin
							state_q <= S_A_ADDR;
						end
					end
					S_A_ADDR: begin
						free_q  <= free_q - req_q;
						res_q   <= '{bcpa_pkg::STAT_OK, cfg.base_addr + prod_q, req_q,
							free_q - req_q};
						state_q <= S_RESP;
					end
					S_F_FIND: begin
						// step through page offsets until one matches, passes the offset or leaves the map
						if (!in_range) begin
							res_q   <= '{bcpa_pkg::STAT_NOT_FOUND, '0, '0, free_q};
							state_q <= S_RESP;
						end else if (acc_q == {1'b0, off_q}) begin
							start_q <= ptr_q;
							left_q  <= req_q;
							if (({1'b0, ptr_q} + {1'b0, req_q}) > {1'b0, cfg.managed}) begin
								res_q   <= '{bcpa_pkg::STAT_NOT_ALLOC, '0, '0, free_q};
								state_q <= S_RESP;
							end else if (req_q == '0) begin
								res_q   <= '{bcpa_pkg::STAT_OK, addr_q, '0, free_q};
								state_q <= S_RESP;
							end else begin
								state_q <= S_F_CHECK;
							end
						end else if (acc_q > {1'b0, off_q}) begin
							res_q   <= '{bcpa_pkg::STAT_NOT_FOUND, '0, '0, free_q};
							state_q <= S_RESP;
						end else begin
							acc_q <= acc_q + XW'(PAGE_BYTES);
							ptr_q <= ptr_q + 1'b1;
						end
					end
					S_F_CHECK: begin
						if (issue) begin
							ptr_q  <= ptr_q + 1'b1;
							left_q <= left_q - 1'b1;
						end
						if (rd_v_s1 && !ram_rdata) begin
							res_q   <= '{bcpa_pkg::STAT_NOT_ALLOC, '0, '0, free_q};
							state_q <= S_RESP;
						end else if (!issue && !rd_v_s1) begin
							ptr_q   <= start_q;
							left_q  <= req_q;
							state_q <= S_F_REL;
						end
					end
					S_F_REL: begin
						ptr_q  <= ptr_q + 1'b1;
						left_q <= left_q - 1'b1;
						if (left_q == CW'(1)) begin
							free_q  <= free_q + req_q;
							res_q   <= '{bcpa_pkg::STAT_OK, addr_q, req_q, free_q + req_q};
							state_q <= S_RESP;
						end
					end
					S_RESP: begin
						if (res_ready) begin
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

`ifndef ASSERT_OFF
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= cfg.managed)
		else $error("free count above managed page count");

	a_mark_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_A_MARK) |-> (ram_we && ram_wdata))
		else $error("marking cycle without a used-bit write");

	a_no_rw_mix: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re)
		else $error("map read issued during a write sweep");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("new request taken right after accept");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != bcpa_pkg::STAT_OK) |->
		(res.run_addr == '0 && res.run_pages == '0))
		else $error("failed result carries address or pages");
`endif

endmodule

FILE: bench/bcpa_result_check.sv
`timescale 1ns / 100ps
// Result checker for the bitmap page allocator: keeps its own page map, predicts each result.
// Depends on bcpa_pkg; watches the request, result and register channels of the core.
module bcpa_result_check #(
	parameter int MAX_PAGES  = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // [10:0] page_request, [42:11] free_addr, rest zero
	input  logic [0:0]  s_tuser,   // [0] opcode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,   // [31:0] run_addr, [42:32] run_pages, [53:43] free_left
	input  logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          checked
);

	localparam int MAX_REPORTS = 150;

	// Shadow of the allocator state
	bit                          page_used [MAX_PAGES];
	logic [bcpa_pkg::CNT_W-1:0]  shadow_free;
	logic [bcpa_pkg::ADDR_W-1:0] map_base;
	logic [bcpa_pkg::CNT_W-1:0]  map_pages;
	bcpa_pkg::res_t              due_results [$];

	// Apply one request to the shadow map and return the result it must give
	function automatic bcpa_pkg::res_t serve_request(input logic op,
		input logic [bcpa_pkg::CNT_W-1:0] want, input logic [bcpa_pkg::ADDR_W-1:0] addr);
		bcpa_pkg::res_t              r;
		int                          run;
		int                          first;
		int                          idx;
		logic                        found;
		logic                        hole;
		logic [bcpa_pkg::ADDR_W-1:0] off;
		r.status    = bcpa_pkg::STAT_NO_SPACE;
		r.run_addr  = '0;
		r.run_pages = '0;
		found       = 1'b0;
		if (op == bcpa_pkg::OP_ALLOC) begin
			// first fit: lowest run of free pages long enough
			if (want != 0 && want <= shadow_free) begin
				run = 0;
				for (int i = 0; i < map_pages && !found; i++) begin
					if (page_used[i]) begin
						run = 0;
					end else begin
						run++;
						if (run == want) begin
							found = 1'b1;
							first = i + 1 - want;
							for (int k = first; k <= i; k++)
								page_used[k] = 1'b1;
							shadow_free = shadow_free - want;
							r.status    = bcpa_pkg::STAT_OK;
							r.run_addr  = map_base + first * PAGE_BYTES;
							r.run_pages = want;
						end
					end
				end
			end
		end else begin
			// free: aligned, in range, whole run inside the map and in use
			off      = addr - map_base;
			r.status = bcpa_pkg::STAT_NOT_FOUND;
			if (off % PAGE_BYTES == 0 && off / PAGE_BYTES < map_pages) begin
				idx      = off / PAGE_BYTES;
				r.status = bcpa_pkg::STAT_NOT_ALLOC;
				if (idx + want <= map_pages) begin
					hole = 1'b0;
					for (int i = 0; i < want; i++)
						if (!page_used[idx + i])
							hole = 1'b1;
					if (!hole) begin
						for (int i = 0; i < want; i++)
							page_used[idx + i] = 1'b0;
						shadow_free = shadow_free + want;
						r.status    = bcpa_pkg::STAT_OK;
						r.run_addr  = addr;
						r.run_pages = want;
					end
				end
			end
		end
		r.free_left = shadow_free;
		return r;
	endfunction

	task automatic note_field(input string name, input logic [bcpa_pkg::ADDR_W-1:0] exp,
		input logic [bcpa_pkg::ADDR_W-1:0] act);
		if (exp !== act) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s expected %h, got %h", $time, name, exp, act);
		end
	endtask

	// Compare results, track register writes, predict accepted requests
	always @(posedge clk or negedge arst_n) begin : watch
		bcpa_pkg::res_t exp;
		int             n;
		if (!arst_n) begin
			foreach (page_used[i])
				page_used[i] = 1'b0;
			shadow_free = '0;
			map_base    = '0;
			map_pages   = '0;
			due_results.delete();
			fail_count = 0;
			checked    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				checked++;
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: result with no request outstanding, expected none, got %h %h",
							$time, m_tuser, m_tdata);
				end else begin
					exp = due_results.pop_front();
					note_field("status", bcpa_pkg::ADDR_W'(exp.status),
						bcpa_pkg::ADDR_W'(m_tuser));
					note_field("run_addr", exp.run_addr, m_tdata[bcpa_pkg::ADDR_W-1:0]);
					note_field("run_pages", bcpa_pkg::ADDR_W'(exp.run_pages),
						bcpa_pkg::ADDR_W'(m_tdata[bcpa_pkg::ADDR_W +: bcpa_pkg::CNT_W]));
					note_field("free_left", bcpa_pkg::ADDR_W'(exp.free_left),
						bcpa_pkg::ADDR_W'(m_tdata[bcpa_pkg::ADDR_W + bcpa_pkg::CNT_W +:
						bcpa_pkg::CNT_W]));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bcpa_pkg::CFG_BASE_ADDR) begin
					map_base = cfg_data;
				end else if (cfg_index == bcpa_pkg::CFG_MANAGED_PAGES) begin
					// count saturates at the map size; map is cleared
					n = int'(cfg_data[bcpa_pkg::CNT_W-1:0]);
					if (n > MAX_PAGES)
						n = MAX_PAGES;
					map_pages   = bcpa_pkg::CNT_W'(n);
					shadow_free = bcpa_pkg::CNT_W'(n);
					foreach (page_used[i])
						page_used[i] = 1'b0;
				end
			end
			if (s_tvalid && s_tready)
				due_results.push_back(serve_request(s_tuser[0],
					s_tdata[bcpa_pkg::CNT_W-1:0],
					s_tdata[bcpa_pkg::CNT_W +: bcpa_pkg::ADDR_W]));
		end
		pending = due_results.size();
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the page allocator bench: clock, reset, request and register stimulus, verdict.
// Depends on bcpa_pkg, bitmap_contiguous_page_allocator_core and bcpa_result_check.
module tb_top;

	localparam int MAX_PAGES   = 1024;
	localparam int PAGE_BYTES  = 4096;
	localparam int RAND_ITEMS  = 580;
	localparam int CYCLE_LIMIT = 12_000_000;

	typedef struct packed {
		logic [bcpa_pkg::ADDR_W-1:0] addr;
		logic [bcpa_pkg::CNT_W-1:0]  pages;
	} span_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // [10:0] page_request, [42:11] free_addr, rest zero
	logic [0:0]  s_tuser = '0;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [55:0] m_tdata;        // [31:0] run_addr, [42:32] run_pages, [53:43] free_left
	logic [1:0]  m_tuser;        // [1:0] status
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int fail_count;
	int pending;
	int checked;
	int cycles = 0;
	int stall_pct = 0;
	int burst_left = 0;
	int sent = 0;
	int granted = 0;
	int released = 0;
	int settings = 0;

	// What the stimulus knows of the current map
	logic [bcpa_pkg::ADDR_W-1:0] base_now = '0;
	int                          pages_now = 0;
	span_t                       live_runs [$];
	span_t                       freed_runs [$];
	logic                        op_order [$];

	bitmap_contiguous_page_allocator_core #(
		.MAX_PAGES (MAX_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	bcpa_result_check #(
		.MAX_PAGES (MAX_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_result_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hang guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Stopped after %0d cycles with %0d results outstanding", cycles, pending);
			$display("FAIL");
			$finish;
		end
	end

	// Result side stalls at a randomly chosen rate of 0, 30, 60 or 90 percent
	always @(negedge clk) begin
		if (cycles % 256 == 0) begin
			case ($urandom_range(0, 4))
				0, 1: stall_pct = 0;
				2: stall_pct = 30;
				3: stall_pct = 60;
				default: stall_pct = 90;
			endcase
		end
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Follow requests and results so frees can target live runs
	always @(posedge clk) begin
		if (m_tvalid && m_tready && op_order.size() != 0) begin
			if (m_tuser == bcpa_pkg::STAT_OK) begin
				if (op_order[0] == bcpa_pkg::OP_ALLOC) begin
					live_runs.push_back({m_tdata[bcpa_pkg::ADDR_W-1:0],
						m_tdata[bcpa_pkg::ADDR_W +: bcpa_pkg::CNT_W]});
					granted++;
				end else begin
					released++;
				end
			end
			void'(op_order.pop_front());
		end
		if (s_tvalid && s_tready) begin
			op_order.push_back(s_tuser[0]);
			sent++;
		end
	end

	function automatic logic [bcpa_pkg::ADDR_W-1:0] page_at(input int idx);
		return base_now + idx * PAGE_BYTES;
	endfunction

	// One request; bursts of random length with idle gaps in between
	task automatic send_request(input logic op, input int want,
		input logic [bcpa_pkg::ADDR_W-1:0] addr);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'b0, addr, want[bcpa_pkg::CNT_W-1:0]};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [bcpa_pkg::CIDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// New map setting: base first, then the page count, which clears the map
	task automatic set_map(input logic [bcpa_pkg::ADDR_W-1:0] base, input int pages);
		settle();
		cfg_write(bcpa_pkg::CFG_BASE_ADDR, base);
		cfg_write(bcpa_pkg::CFG_MANAGED_PAGES, pages);
		base_now  = base;
		pages_now = (pages > MAX_PAGES) ? MAX_PAGES : pages;
		live_runs.delete();
		freed_runs.delete();
		settings++;
	endtask

	// Mostly allocations and frees of live runs, the rest malformed frees
	task automatic random_request();
		int                          pick;
		int                          mode;
		int                          j;
		int                          k;
		int                          idx;
		int                          want;
		span_t                       run;
		logic [bcpa_pkg::ADDR_W-1:0] addr;
		pick = $urandom_range(0, 99);
		addr = $urandom();
		want = $urandom_range(0, 8);
		if (pick < 45 || (pick < 80 && live_runs.size() == 0)) begin
			case ($urandom_range(0, 9))
				0: want = 0;
				1: want = $urandom_range(0, 2047);
				2, 3: want = $urandom_range(1, pages_now + 1);
				default: want = $urandom_range(1, pages_now / 4 + 1);
			endcase
			send_request(bcpa_pkg::OP_ALLOC, want, addr);
		end else if (pick < 80) begin
			// release a whole live run, its head or its tail
			j    = $urandom_range(0, live_runs.size() - 1);
			run  = live_runs[j];
			k    = $urandom_range(1, run.pages);
			mode = $urandom_range(0, 2);
			if (mode == 0 || k == run.pages) begin
				live_runs.delete(j);
				freed_runs.push_back(run);
				if (freed_runs.size() > 16)
					void'(freed_runs.pop_front());
				send_request(bcpa_pkg::OP_FREE, int'(run.pages), run.addr);
			end else if (mode == 1) begin
				live_runs[j].addr  = run.addr + k * PAGE_BYTES;
				live_runs[j].pages = bcpa_pkg::CNT_W'(run.pages - k);
				send_request(bcpa_pkg::OP_FREE, k, run.addr);
			end else begin
				live_runs[j].pages = bcpa_pkg::CNT_W'(run.pages - k);
				send_request(bcpa_pkg::OP_FREE, k, run.addr + (run.pages - k) * PAGE_BYTES);
			end
		end else begin
			case ($urandom_range(0, 6))
				0: addr = page_at($urandom_range(0, pages_now + 1))
					+ $urandom_range(1, PAGE_BYTES - 1);
				1: addr = page_at(pages_now + $urandom_range(0, 64));
				2: ;
				3: begin
					if (freed_runs.size() != 0) begin
						run  = freed_runs[$urandom_range(0, freed_runs.size() - 1)];
						addr = run.addr;
						want = int'(run.pages);
					end
				end
				4: begin
					idx  = $urandom_range(0, pages_now);
					addr = page_at(idx);
					want = $urandom_range(1, pages_now - idx + 2);
				end
				5: begin
					addr = page_at($urandom_range(0, pages_now));
					want = 0;
				end
				default: begin
					addr = page_at($urandom_range(0, pages_now));
					want = $urandom_range(0, 2047);
				end
			endcase
			send_request(bcpa_pkg::OP_FREE, want, addr);
		end
	endtask

	initial begin : stimulus
		logic [bcpa_pkg::ADDR_W-1:0] base;
		int                          pages;
		int                          n;
		int                          rand_done;
		rand_done = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Nothing managed after reset
		send_request(bcpa_pkg::OP_ALLOC, 1, '0);
		send_request(bcpa_pkg::OP_FREE, 1, '0);

		// Small map: zero, oversize and exact fits, every kind of bad free
		set_map(32'h1000_0000, 8);
		send_request(bcpa_pkg::OP_ALLOC, 0, '0);
		send_request(bcpa_pkg::OP_ALLOC, 9, '0);
		send_request(bcpa_pkg::OP_ALLOC, 3, '1);
		send_request(bcpa_pkg::OP_ALLOC, 5, '0);
		send_request(bcpa_pkg::OP_ALLOC, 1, '0);
		send_request(bcpa_pkg::OP_FREE, 0, page_at(3));
		send_request(bcpa_pkg::OP_FREE, 2, page_at(1));
		send_request(bcpa_pkg::OP_FREE, 1, page_at(1));
		send_request(bcpa_pkg::OP_FREE, 1, page_at(2) + 32'h800);
		send_request(bcpa_pkg::OP_FREE, 1, page_at(8));
		send_request(bcpa_pkg::OP_FREE, 1, page_at(-1));
		send_request(bcpa_pkg::OP_FREE, 3, page_at(6));
		send_request(bcpa_pkg::OP_FREE, 2047, page_at(0));
		send_request(bcpa_pkg::OP_ALLOC, 2047, '0);
		send_request(bcpa_pkg::OP_ALLOC, 2, '0);
		send_request(bcpa_pkg::OP_FREE, 1, '1);

		// Oversize count saturates; addresses wrap past the top
		set_map(32'hFFFF_E000, 2047);
		send_request(bcpa_pkg::OP_ALLOC, MAX_PAGES, '0);
		send_request(bcpa_pkg::OP_ALLOC, 1, '0);
		send_request(bcpa_pkg::OP_FREE, 1, page_at(MAX_PAGES - 1));
		send_request(bcpa_pkg::OP_ALLOC, 1, '0);
		send_request(bcpa_pkg::OP_FREE, MAX_PAGES, page_at(0));

		// Random phases, mostly small maps
		while (rand_done < RAND_ITEMS) begin
			case ($urandom_range(0, 11))
				0: pages = 0;
				1: pages = $urandom_range(MAX_PAGES / 2, 2047);
				2: pages = 1;
				default: pages = $urandom_range(2, 48);
			endcase
			case ($urandom_range(0, 5))
				0: base = '0;
				1: base = 32'h0 - $urandom_range(1, 16) * PAGE_BYTES;
				2: base = $urandom();
				default: base = $urandom() & ~(PAGE_BYTES - 1);
			endcase
			set_map(base, pages);
			if (pages_now > 256)
				n = $urandom_range(4, 10);
			else if (pages_now == 0)
				n = 4;
			else
				n = $urandom_range(25, 60);
			repeat (n) random_request();
			rand_done += n;
		end

		settle();
		repeat (64) @(negedge clk);
		$display("Sent %0d requests over %0d map settings, empty and saturated maps included.",
			sent, settings);
		$display("%0d runs granted, %0d released, %0d results checked, %0d mismatches.",
			granted, released, checked, fail_count);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
